@@ hw/rtl/srdf_pkg.sv @@
// Shared types and constants for the shadow register dirty-flush block.
// Field widths, action codes and the shadow write request; no dependencies.
package srdf_pkg;

  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 10;
  localparam int FRAME_W       = ADDR_W + DATA_W;
  localparam int NUM_REGS_DEF  = 32;

  typedef enum logic [1:0] {
    ACT_SET       = 2'd0,
    ACT_FLUSH     = 2'd1,
    ACT_FLUSH_ONE = 2'd2,
    ACT_MARK_ALL  = 2'd3
  } action_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } shd_wr_t;

endpackage

@@ hw/rtl/srdf_shadow.sv @@
// Shadow value store: one write port, one registered read port.
// Entries never written since reset read as zero. Uses srdf_pkg.
module srdf_shadow #(
  parameter int NUM_REGS = srdf_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srdf_pkg::shd_wr_t             wr,
  input  logic                          rd_en,
  input  logic [srdf_pkg::ADDR_W-1:0]   rd_addr,
  output logic [srdf_pkg::DATA_W-1:0]   rd_data
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [srdf_pkg::DATA_W-1:0] mem [NUM_REGS];
  logic [NUM_REGS-1:0]         written;
  logic [srdf_pkg::DATA_W-1:0] rd_q;
  logic                        rd_ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr[IDX_W-1:0]];
      rd_ok <= written[rd_addr[IDX_W-1:0]];
    end
  end

  // unwritten entries hold the reset value of zero
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

@@ hw/rtl/shadow_register_dirty_flush.sv @@
// Shadow register file with dirty tracking; emits write frames on flush.
// Set and mark-all never stall the input; flush-one goes through S_LOAD and S_SEND to the output register.
// Flush scans one address per cycle up to the highest dirty one, stepping through
// S_LOAD and S_SEND for each dirty word and waiting while the output stalls; no new word meanwhile.
// Synchronous reset clears dirty bits, shadow contents (read as zero) and out_valid.
// Uses srdf_pkg and srdf_shadow.
module shadow_register_dirty_flush #(
  parameter int NUM_REGS = srdf_pkg::NUM_REGS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     action,
  input  logic [srdf_pkg::ADDR_W-1:0]    address,
  input  logic [srdf_pkg::DATA_W-1:0]    value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [srdf_pkg::FRAME_W-1:0]   spi_frame,
  output logic                           last
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [srdf_pkg::ADDR_W:0] REG_LIM = (srdf_pkg::ADDR_W + 1)'(NUM_REGS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LOAD = 4'b0100,
    S_SEND = 4'b1000
  } state_t;

  state_t                       state, state_next;
  logic [IDX_W-1:0]             idx, idx_next;
  logic                         one_mode, one_mode_next;
  logic [NUM_REGS-1:0]          dirty, dirty_next;
  logic [NUM_REGS-1:0]          idx_bit;
  logic                         in_acc;
  logic                         addr_ok;
  logic                         load_out;
  logic                         frame_last;
  srdf_pkg::action_t            act;
  srdf_pkg::shd_wr_t            wr;
  logic [srdf_pkg::DATA_W-1:0]  rd_data;

  assign act      = srdf_pkg::action_t'(action);
  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign addr_ok  = ({1'b0, address} < REG_LIM);
  assign load_out = (state == S_SEND) && (!out_valid || !out_stall);

  always_comb begin
    idx_bit      = '0;
    idx_bit[idx] = 1'b1;
  end

  assign frame_last = one_mode || ((dirty & ~idx_bit) == '0);

  assign wr.en   = in_acc && (act == srdf_pkg::ACT_SET) && addr_ok;
  assign wr.addr = address;
  assign wr.data = value;

  srdf_shadow #(
    .NUM_REGS (NUM_REGS)
  ) u_shadow (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (state == S_LOAD),
    .rd_addr (srdf_pkg::ADDR_W'(idx)),
    .rd_data (rd_data)
  );

  always_comb begin
    dirty_next = dirty;
    if (in_acc) begin
      unique case (act)
        srdf_pkg::ACT_SET: begin
          if (addr_ok) dirty_next[address[IDX_W-1:0]] = 1'b1;
        end
        srdf_pkg::ACT_FLUSH_ONE: begin
          if (addr_ok) dirty_next[address[IDX_W-1:0]] = 1'b0;
        end
        srdf_pkg::ACT_MARK_ALL: begin
          dirty_next = '1;
        end
        default: begin
          // flush leaves bits for the scan to clear
        end
      endcase
    end
    // drop each dirty bit as its word goes out
    if (load_out && !one_mode) begin
      dirty_next = dirty & ~idx_bit;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    one_mode_next = one_mode;
    unique case (state)
      S_IDLE: begin
        if (in_acc && act == srdf_pkg::ACT_FLUSH && dirty != '0) begin
          idx_next      = '0;
          one_mode_next = 1'b0;
          state_next    = S_SCAN;
        end else if (in_acc && act == srdf_pkg::ACT_FLUSH_ONE && addr_ok) begin
          idx_next      = address[IDX_W-1:0];
          one_mode_next = 1'b1;
          state_next    = S_LOAD;
        end
      end
      S_SCAN: begin
        if (dirty[idx]) begin
          state_next = S_LOAD;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_LOAD: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (load_out) begin
          if (frame_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      one_mode <= 1'b0;
      dirty    <= '0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      one_mode <= one_mode_next;
      dirty    <= dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      spi_frame <= {srdf_pkg::ADDR_W'(idx), rd_data};
      last      <= frame_last;
    end
  end

  // scan runs only while something is still dirty
  a_scan_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (dirty != '0))
    else $error("scan with no dirty bit left");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (load_out && !one_mode && frame_last) |=> (dirty == '0))
    else $error("dirty bits left after final flush word");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load_out && frame_last) |=> (state == S_IDLE))
    else $error("sequencer busy after final word");

  a_sent_clean: assert property (@(posedge clk) disable iff (rst)
    (load_out && !one_mode) |=> !dirty[$past(idx)])
    else $error("dirty bit kept for a flushed word");

endmodule

@@ test/srdf_checker.sv @@
// Checker for the shadow register dirty-flush block: watches both channels,
// keeps its own shadow copy and dirty mask, and compares every write frame.
// Depends on srdf_pkg for widths and action codes.
module srdf_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   action,
  input  logic [srdf_pkg::ADDR_W-1:0]  address,
  input  logic [srdf_pkg::DATA_W-1:0]  value,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [srdf_pkg::FRAME_W-1:0] spi_frame,
  input  logic                         last,
  output int                           fail_count,
  output int                           pending,
  output int                           words_seen,
  output int                           frames_seen
);

  typedef struct packed {
    logic [srdf_pkg::FRAME_W-1:0] frame;
    logic                         last;
  } frame_exp_t;

  logic [srdf_pkg::DATA_W-1:0]       shadow [srdf_pkg::NUM_REGS_DEF];
  logic [srdf_pkg::NUM_REGS_DEF-1:0] dirty;
  frame_exp_t                        frames_due [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    words_seen  = 0;
    frames_seen = 0;
  end

  function automatic logic [srdf_pkg::FRAME_W-1:0] write_frame(
      logic [srdf_pkg::ADDR_W-1:0] a);
    return {a, shadow[a]};
  endfunction

  // Update the shadow copy for one word and queue the frames it causes.
  task automatic apply_word(srdf_pkg::action_t act, logic [srdf_pkg::ADDR_W-1:0] a,
                            logic [srdf_pkg::DATA_W-1:0] v);
    case (act)
      srdf_pkg::ACT_SET: begin
        shadow[a] = v;
        dirty[a]  = 1'b1;
      end
      srdf_pkg::ACT_FLUSH: begin
        for (int i = 0; i < srdf_pkg::NUM_REGS_DEF; i++) begin
          // the highest dirty address carries last
          if (dirty[i])
            frames_due.push_back({write_frame(srdf_pkg::ADDR_W'(i)),
                                  (dirty >> (i + 1)) == '0});
        end
        dirty = '0;
      end
      srdf_pkg::ACT_FLUSH_ONE: begin
        frames_due.push_back({write_frame(a), 1'b1});
        dirty[a] = 1'b0;
      end
      srdf_pkg::ACT_MARK_ALL: begin
        dirty = '1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    frame_exp_t head;
    if (rst) begin
      for (int i = 0; i < srdf_pkg::NUM_REGS_DEF; i++)
        shadow[i] = '0;
      dirty = '0;
      frames_due.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          fail_count++;
          $error("spi_frame %h (last %b) arrived with no frame pending", spi_frame, last);
        end else begin
          head = frames_due.pop_front();
          if (spi_frame !== head.frame) begin
            fail_count++;
            $error("spi_frame mismatch: expected %h, got %h", head.frame, spi_frame);
          end
          if (last !== head.last) begin
            fail_count++;
            $error("last mismatch: expected %b, got %b", head.last, last);
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        words_seen++;
        apply_word(srdf_pkg::action_t'(action), address, value);
      end
    end
    pending <= frames_due.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top for shadow_register_dirty_flush: clock, reset, stimulus and verdict.
// Depends on srdf_pkg, the block itself and srdf_checker, which does the comparing.
module tb;

  localparam int WORDS_RANDOM = 450;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 150;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [1:0]                   action    = srdf_pkg::ACT_SET;
  logic [srdf_pkg::ADDR_W-1:0]  address   = '0;
  logic [srdf_pkg::DATA_W-1:0]  value     = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [srdf_pkg::FRAME_W-1:0] spi_frame;
  logic                         last;

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;

  int fail_count;
  int pending;
  int words_seen;
  int frames_seen;

  shadow_register_dirty_flush DUT (.*);

  srdf_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("shadow_register_dirty_flush test failed");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [srdf_pkg::ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 99) < 20)
      return $urandom_range(0, 1) ? '1 : '0;
    return srdf_pkg::ADDR_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [srdf_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 15)
      return $urandom_range(0, 1) ? '1 : '0;
    return srdf_pkg::DATA_W'($urandom_range(0, 1023));
  endfunction

  // Offer one word, hold it until taken, then, unless quiet, idle for a random gap about half the time.
  task automatic send_word(srdf_pkg::action_t act, logic [srdf_pkg::ADDR_W-1:0] a,
                           logic [srdf_pkg::DATA_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    action   <= act;
    address  <= a;
    value    <= v;
    do @(posedge clk); while (in_stall);
    gap = (quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none while quiet.
  initial begin
    int n;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 99) < 35) begin
          out_stall <= 1'b1;
          n = idle_len();
        end else begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 8);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    int roll;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flush, clean single flush, field extremes, a full flush
    send_word(srdf_pkg::ACT_FLUSH,     5'd0,  10'h000);
    send_word(srdf_pkg::ACT_FLUSH_ONE, 5'd0,  10'h3ff);
    send_word(srdf_pkg::ACT_SET,       5'd0,  10'h3ff);
    send_word(srdf_pkg::ACT_SET,       5'd31, 10'h000);
    send_word(srdf_pkg::ACT_SET,       5'd31, 10'h3ff);
    send_word(srdf_pkg::ACT_SET,       5'd5,  10'h155);
    send_word(srdf_pkg::ACT_SET,       5'd10, 10'h2aa);
    send_word(srdf_pkg::ACT_FLUSH,     5'd31, 10'h3ff);
    send_word(srdf_pkg::ACT_FLUSH,     5'd0,  10'h000);
    send_word(srdf_pkg::ACT_MARK_ALL,  5'd0,  10'h000);
    send_word(srdf_pkg::ACT_FLUSH,     5'd0,  10'h000);
    send_word(srdf_pkg::ACT_SET,       5'd7,  10'h001);
    send_word(srdf_pkg::ACT_FLUSH_ONE, 5'd7,  10'h000);
    send_word(srdf_pkg::ACT_FLUSH,     5'd0,  10'h000);
    send_word(srdf_pkg::ACT_SET,       5'd3,  10'h200);
    send_word(srdf_pkg::ACT_SET,       5'd3,  10'h0ff);
    send_word(srdf_pkg::ACT_FLUSH_ONE, 5'd3,  10'h000);
    send_word(srdf_pkg::ACT_FLUSH_ONE, 5'd3,  10'h000);
    send_word(srdf_pkg::ACT_MARK_ALL,  5'd31, 10'h3ff);
    send_word(srdf_pkg::ACT_FLUSH_ONE, 5'd31, 10'h000);
    send_word(srdf_pkg::ACT_FLUSH,     5'd0,  10'h000);

    for (int n = 0; n < WORDS_RANDOM; n++) begin
      if (n == 120) begin
        // fill the block while the receiver holds off
        hold_req <= 1'b1;
        send_word(srdf_pkg::ACT_MARK_ALL, pick_addr(), pick_value());
        send_word(srdf_pkg::ACT_FLUSH, pick_addr(), pick_value());
      end
      if (n == 200)
        quiet <= 1'b1;
      if (n == 260)
        quiet <= 1'b0;
      if (n == 320) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      if (roll < 10)
        send_word(srdf_pkg::ACT_MARK_ALL, pick_addr(), pick_value());
      else if (roll < 25)
        send_word(srdf_pkg::ACT_FLUSH, pick_addr(), pick_value());
      else if (roll < 45)
        send_word(srdf_pkg::ACT_FLUSH_ONE, pick_addr(), pick_value());
      else
        send_word(srdf_pkg::ACT_SET, pick_addr(), pick_value());
    end
    in_valid <= 1'b0;

    // drain every expected frame, then watch a while for stray ones
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (sets, flushes, single flushes, mark-all) and checked %0d frames,",
             words_seen, frames_seen);
    $display("including full 32-frame flushes, a long output hold-off and an idle-free stretch.");
    if (fail_count == 0 && pending == 0)
      $display("shadow_register_dirty_flush test passed");
    else
      $display("shadow_register_dirty_flush test failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/srdf_pkg.sv
hw/rtl/srdf_shadow.sv
hw/rtl/shadow_register_dirty_flush.sv
test/srdf_checker.sv
test/tb.sv
